[hdl/word_token_normalizer_defines.svh]
// ---------------------------------------------------------------------------
// word_token_normalizer assertion macros
// Shared concurrent assertion forms, clocked on clk with reset rst_n.
// ---------------------------------------------------------------------------
`ifndef WORD_TOKEN_NORMALIZER_DEFINES_SVH
`define WORD_TOKEN_NORMALIZER_DEFINES_SVH

// cond must never be true outside reset
`define WTN_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// ante implies cons in the same cycle
`define WTN_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[hdl/wtn_pkg.sv]
// ---------------------------------------------------------------------------
// wtn_pkg
// Types, character constants and classification helpers of the normalizer.
// ---------------------------------------------------------------------------
package wtn_pkg;

    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_APOS    = 8'h27;
    localparam logic [7:0] CH_LOWER_S = 8'h73;
    localparam logic [7:0] CH_UPPER_S = 8'h53;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       last;
    } res_t;

    // results of one input byte, packed from slot 0 upward
    typedef struct packed {
        logic [1:0]       cnt;
        res_t [2:0]       res;
    } entry_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c >= 8'h21 && c <= 8'h7E && !is_letter(c) && !is_digit(c);
    endfunction

    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

endpackage

[hdl/wtn_front.sv]
// ---------------------------------------------------------------------------
// wtn_front
// Accepts token bytes, tracks strip/pattern/tail state and forms the
// results of each byte as one queue entry.
// ---------------------------------------------------------------------------
module wtn_front
    import wtn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_char,
    input  logic       token_is_word,
    input  logic       last_char,
    input  logic       q_full,
    output logic       q_push,
    output entry_t     q_entry
);

    logic       lead_reg, lead_next;
    logic       odd_reg, odd_next;
    logic       ph_reg, ph_next;
    logic [1:0] pos_reg, pos_next;
    logic [1:0] tc_reg, tc_next;
    logic [7:0] tb0_reg, tb0_next;
    logic [7:0] tb1_reg, tb1_next;

    logic       accept;
    logic       ph_v;
    logic       keep;
    logic [7:0] kept_byte;
    logic [7:0] t0, t1;
    logic [1:0] tc;
    logic [1:0] k;
    entry_t     ent;

    assign full   = q_full;
    assign accept = push && !q_full && token_is_word;

    always_comb
    begin
        lead_next = lead_reg;
        odd_next  = odd_reg;
        ph_next   = ph_reg;
        pos_next  = pos_reg;
        ph_v      = ph_reg;
        keep      = 1'b0;
        kept_byte = fold_lower(in_char);
        ent       = '0;
        k         = 2'd0;

        if (!(lead_reg && is_punct(in_char)))
        begin
            lead_next = 1'b0;
            if (odd_reg)
            begin
                if (in_char != CH_DOT)
                    ph_v = 1'b0;
            end
            else if (!is_letter(in_char))
            begin
                ph_v = 1'b0;
            end
            ph_next = ph_v;
            // drop pattern dots, but keep a dot that is the second unstripped byte and ends the token
            if (in_char == CH_DOT && ph_v)
            begin
                if (pos_reg == 2'd1 && last_char)
                begin
                    keep      = 1'b1;
                    kept_byte = in_char;
                end
            end
            else
            begin
                keep = 1'b1;
            end
            if (pos_reg != 2'd2)
                pos_next = pos_reg + 2'd1;
            odd_next = !odd_reg;
        end

        t0 = tb0_reg;
        t1 = tb1_reg;
        tc = tc_reg;
        if (keep)
        begin
            unique case (tc)
                2'd0:
                begin
                    t0 = kept_byte;
                    tc = 2'd1;
                end
                2'd1:
                begin
                    t1 = kept_byte;
                    tc = 2'd2;
                end
                default:
                begin
                    // advance the tail, oldest byte leaves
                    ent.res[0] = '{ch: t0, valid: 1'b1, last: 1'b0};
                    k  = 2'd1;
                    t0 = t1;
                    t1 = kept_byte;
                end
            endcase
        end

        tb0_next = t0;
        tb1_next = t1;
        tc_next  = tc;

        if (last_char)
        begin
            if (tc == 2'd2 && t0 == CH_APOS && (t1 == CH_LOWER_S || t1 == CH_UPPER_S))
                tc = 2'd0;
            else if (tc == 2'd2 && t1 == CH_APOS)
                tc = 2'd1;
            else if (tc == 2'd1 && t0 == CH_APOS)
                tc = 2'd0;

            if (tc == 2'd0)
            begin
                ent.res[k] = '{ch: 8'h00, valid: 1'b0, last: 1'b1};
                k = k + 2'd1;
            end
            else
            begin
                ent.res[k] = '{ch: t0, valid: 1'b1, last: (tc == 2'd1)};
                k = k + 2'd1;
                if (tc == 2'd2)
                begin
                    ent.res[k] = '{ch: t1, valid: 1'b1, last: 1'b1};
                    k = k + 2'd1;
                end
            end

            lead_next = 1'b1;
            odd_next  = 1'b0;
            ph_next   = 1'b1;
            pos_next  = 2'd0;
            tc_next   = 2'd0;
            tb0_next  = 8'h00;
            tb1_next  = 8'h00;
        end
        ent.cnt = k;
    end

    assign q_push  = accept && (k != 2'd0);
    assign q_entry = ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg <= 1'b1;
            odd_reg  <= 1'b0;
            ph_reg   <= 1'b1;
            pos_reg  <= 2'd0;
            tc_reg   <= 2'd0;
            tb0_reg  <= 8'h00;
            tb1_reg  <= 8'h00;
        end
        else if (accept)
        begin
            lead_reg <= lead_next;
            odd_reg  <= odd_next;
            ph_reg   <= ph_next;
            pos_reg  <= pos_next;
            tc_reg   <= tc_next;
            tb0_reg  <= tb0_next;
            tb1_reg  <= tb1_next;
        end
    end

endmodule

[hdl/wtn_queue.sv]
// ---------------------------------------------------------------------------
// wtn_queue
// Short FIFO of result entries between the front and back parts.
// ---------------------------------------------------------------------------
module wtn_queue
    import wtn_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr,
    input  entry_t wr_data,
    output logic   full,
    output logic   avail,
    output entry_t head,
    input  logic   rd
);

    entry_t         mem_reg [QDEPTH];
    logic [QAW-1:0] wp_reg, rp_reg;
    logic [QAW:0]   cnt_reg, cnt_next;
    logic           do_wr, do_rd;

    assign full  = (cnt_reg == (QAW+1)'(QDEPTH));
    assign avail = (cnt_reg != '0);
    assign head  = mem_reg[rp_reg];
    assign do_wr = wr && !full;
    assign do_rd = rd && avail;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= wp_reg + 1'b1;
            if (do_rd)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wr_data;
    end

endmodule

[hdl/wtn_back.sv]
// ---------------------------------------------------------------------------
// wtn_back
// Walks the slots of each queue entry and hands results to the output
// register, one per cycle while the output register is empty or popped.
// ---------------------------------------------------------------------------
module wtn_back
    import wtn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_avail,
    input  entry_t     q_head,
    output logic       q_rd,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_char,
    output logic       char_valid,
    output logic       token_end
);

    logic [1:0] idx_reg;
    logic       ov_reg;
    res_t       out_reg;
    logic       slot_free;
    logic       load;
    logic       final_slot;

    assign slot_free  = !ov_reg || pop;
    assign load       = q_avail && slot_free;
    assign final_slot = (idx_reg == q_head.cnt - 2'd1);
    assign q_rd       = load && final_slot;

    assign empty      = !ov_reg;
    assign out_char   = out_reg.ch;
    assign char_valid = out_reg.valid;
    assign token_end  = out_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            if (load)
                idx_reg <= final_slot ? 2'd0 : idx_reg + 2'd1;
            if (load)
                ov_reg <= 1'b1;
            else if (pop)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= q_head.res[idx_reg];
    end

endmodule

[hdl/word_token_normalizer.sv]
// ---------------------------------------------------------------------------
// word_token_normalizer
// Word token normalizer: strip, lowercase, acronym dots, possessive tail.
// ---------------------------------------------------------------------------
// Input channel: one token byte per transfer (push/full) with token_is_word
// and last_char. Bytes of non-word tokens are consumed and give nothing.
// Result channel: queue style (empty/pop); the oldest result sits on
// out_char/char_valid/token_end while empty is low.
// Throughput: one byte per cycle while full is low. A byte yields zero to
// three results; the back part emits one result per cycle while pop keeps
// the output free, so a token end that flushes the two held tail bytes
// can put up to three results on the output.
// Path: a byte's results are written to the queue at the transfer edge and
// then loaded into the output register, though the last two kept bytes of
// a token are held until the next byte or the token end decides them.
// A four-entry queue between the front and back parts absorbs flushes;
// when the receiver stalls the queue fills and full rises.
// Reset clears token state and the queue and marks the output register empty.
// ---------------------------------------------------------------------------
`include "word_token_normalizer_defines.svh"

module word_token_normalizer
    import wtn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_char,
    input  logic       token_is_word,
    input  logic       last_char,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_char,
    output logic       char_valid,
    output logic       token_end
);

    logic   q_push;
    logic   q_full;
    logic   q_avail;
    logic   q_rd;
    entry_t q_entry;
    entry_t q_head;
    logic   word_end_xfer;
    logic   entry_ends;

    wtn_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .in_char       (in_char),
        .token_is_word (token_is_word),
        .last_char     (last_char),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (q_entry)
    );

    wtn_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .wr_data (q_entry),
        .full    (q_full),
        .avail   (q_avail),
        .head    (q_head),
        .rd      (q_rd)
    );

    wtn_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_avail    (q_avail),
        .q_head     (q_head),
        .q_rd       (q_rd),
        .pop        (pop),
        .empty      (empty),
        .out_char   (out_char),
        .char_valid (char_valid),
        .token_end  (token_end)
    );

    assign word_end_xfer = push && !full && token_is_word && last_char;
    assign entry_ends    = q_entry.res[q_entry.cnt - 2'd1].last;

    `WTN_ASSERT_NEVER(a_no_empty_entry, q_push && (q_entry.cnt == 2'd0), "empty entry")
    `WTN_ASSERT_NEVER(a_bare_marker_ends, !empty && !char_valid && !token_end, "stray marker")
    `WTN_ASSERT_IMPLY(a_word_end_flushes, word_end_xfer, q_push && entry_ends, "end not flushed")

endmodule

[test/word_token_normalizer_test.sv]
// ---------------------------------------------------------------------------
// word_token_normalizer_test
// Drives token bytes through the queue-style input and checks each result
// against a cycle-free model of the normalizer, under several idle mixes
// and one long receiver stall that backs the block up into full.
// ---------------------------------------------------------------------------
module word_token_normalizer_test;
    import wtn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PER_PHASE = 35;

    typedef struct {
        logic [7:0] ch;
        logic       word;
        logic       last;
    } token_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] in_char = 8'h00;
    logic       token_is_word = 1'b0;
    logic       last_char = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] out_char;
    logic       char_valid;
    logic       token_end;

    token_byte_t pending_bytes[$];
    res_t        want_results[$];

    int send_idle = 31;
    int recv_idle = 85;
    int phase = 0;
    int word_items = 0;
    int bad_count = 0;
    int cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    // normalizer state of the model
    logic       strip_lead = 1'b1;
    logic [1:0] pos_cnt = 2'd0;
    logic       pos_odd = 1'b0;
    logic       alt_ok = 1'b1;
    logic [7:0] tail [2] = '{8'h00, 8'h00};
    int         tail_n = 0;

    word_token_normalizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .in_char       (in_char),
        .token_is_word (token_is_word),
        .last_char     (last_char),
        .empty         (empty),
        .pop           (pop),
        .out_char      (out_char),
        .char_valid    (char_valid),
        .token_end     (token_end)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic alpha_byte(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic punct_byte(input logic [7:0] c);
        return c >= 8'h21 && c <= 8'h7E && !alpha_byte(c) && !(c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function automatic res_t make_result(input logic [7:0] c, input logic v, input logic e);
        res_t r;
        r.ch = c;
        r.valid = v;
        r.last = e;
        return r;
    endfunction

    // Shift a kept byte into the two-byte tail; the oldest one goes out.
    task automatic keep_byte(input logic [7:0] c);
        if (tail_n >= 2)
        begin
            want_results.push_back(make_result(tail[0], 1'b1, 1'b0));
            tail[0] = tail[1];
            tail[1] = c;
        end
        else
        begin
            tail[tail_n] = c;
            tail_n++;
        end
    endtask

    task automatic normalize_byte(input logic [7:0] c, input logic w, input logic l);
        if (!w)
            return;
        if (!(strip_lead && punct_byte(c)))
        begin
            strip_lead = 1'b0;
            if (pos_odd)
            begin
                if (c != CH_DOT)
                    alt_ok = 1'b0;
            end
            else if (!alpha_byte(c))
            begin
                alt_ok = 1'b0;
            end
            if (c == CH_DOT && alt_ok)
            begin
                // a dot at position one stays only if the token ends on it
                if (pos_cnt == 2'd1 && l)
                    keep_byte(c);
            end
            else
            begin
                keep_byte(fold_case(c));
            end
            if (pos_cnt < 2'd2)
                pos_cnt++;
            pos_odd = !pos_odd;
        end
        if (l)
        begin
            if (tail_n == 2 && tail[0] == CH_APOS &&
                (tail[1] == CH_LOWER_S || tail[1] == CH_UPPER_S))
                tail_n = 0;
            else if (tail_n >= 1 && tail[tail_n - 1] == CH_APOS)
                tail_n--;
            if (tail_n == 0)
                want_results.push_back(make_result(8'h00, 1'b0, 1'b1));
            else
                for (int i = 0; i < tail_n; i++)
                    want_results.push_back(make_result(tail[i], 1'b1, i + 1 == tail_n));
            strip_lead = 1'b1;
            pos_cnt = 2'd0;
            pos_odd = 1'b0;
            alt_ok = 1'b1;
            tail = '{8'h00, 8'h00};
            tail_n = 0;
        end
    endtask

    task automatic add_byte(input logic [7:0] c, input logic w, input logic l);
        token_byte_t b;
        b.ch = c;
        b.word = w;
        b.last = l;
        pending_bytes.push_back(b);
        if (w)
            word_items++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i], 1'b1, i == s.len() - 1);
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        if ($urandom_range(0, 1))
            c = 8'($urandom_range(8'h41, 8'h5A));
        else
            c = 8'($urandom_range(8'h61, 8'h7A));
        return c;
    endfunction

    function automatic logic [7:0] rand_punct();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: c = 8'($urandom_range(8'h21, 8'h2F));
            1: c = 8'($urandom_range(8'h3A, 8'h40));
            2: c = 8'($urandom_range(8'h5B, 8'h60));
            default: c = 8'($urandom_range(8'h7B, 8'h7E));
        endcase
        return c;
    endfunction

    function automatic logic [7:0] rand_byte();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1, 2: c = rand_letter();
            3:       c = 8'($urandom_range(8'h61, 8'h7A));
            4:       c = CH_DOT;
            5:       c = CH_APOS;
            6:       c = rand_punct();
            7:       c = 8'($urandom_range(8'h30, 8'h39));
            8:       c = $urandom_range(0, 1) ? CH_LOWER_S : CH_UPPER_S;
            default: c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    task automatic add_random_token();
        logic [7:0] body[$];
        int kind;
        int n;
        kind = $urandom_range(0, 19);
        if (kind < 3)
        begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                add_byte(8'($urandom_range(0, 255)), 1'b0, i == n - 1);
            return;
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) body.push_back(rand_punct());
        if (kind < 8)
        begin
            // acronym shape, sometimes broken
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
            begin
                body.push_back(rand_letter());
                if (i < n - 1 || $urandom_range(0, 1))
                    body.push_back(CH_DOT);
            end
            if ($urandom_range(0, 4) == 0)
                body[$urandom_range(0, body.size() - 1)] = rand_byte();
        end
        else if (kind < 12)
        begin
            n = $urandom_range(0, 4);
            repeat (n) body.push_back(rand_letter());
            body.push_back(CH_APOS);
            if ($urandom_range(0, 2) != 0)
                body.push_back($urandom_range(0, 1) ? CH_LOWER_S : CH_UPPER_S);
        end
        else if (kind < 17)
        begin
            repeat ($urandom_range(1, 6)) body.push_back(rand_byte());
        end
        else if (kind < 19)
        begin
            repeat ($urandom_range(1, 3)) body.push_back(rand_punct());
        end
        else
        begin
            repeat ($urandom_range(10, 24)) body.push_back(rand_byte());
        end
        for (int i = 0; i < body.size(); i++)
        begin
            // stray non-word byte inside the word token
            if ($urandom_range(0, 9) == 0)
                add_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
            add_byte(body[i], 1'b1, i == body.size() - 1);
        end
    endtask

    task automatic add_random_phase();
        int target;
        target = word_items + RANDOM_PER_PHASE;
        while (word_items < target)
            add_random_token();
    endtask

    always @(posedge clk)
    begin : drive_proc
        token_byte_t nxt;
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
                normalize_byte(in_char, token_is_word, last_char);
            if (push && full)
            begin
                // hold the offered byte until it transfers
            end
            else if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle)
            begin
                nxt = pending_bytes.pop_front();
                push <= 1'b1;
                in_char <= nxt.ch;
                token_is_word <= nxt.word;
                last_char <= nxt.last;
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // one long stall while the sender keeps offering
    always @(posedge clk)
    begin : hold_proc
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (phase == 2 && !hold_done)
        begin
            hold_left <= 80;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk)
    begin : check_proc
        res_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (want_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual ch %h valid %b end %b",
                             $time, out_char, char_valid, token_end);
                    bad_count++;
                end
                else
                begin
                    want = want_results.pop_front();
                    if (out_char !== want.ch)
                    begin
                        $display("%0t: out_char expected %h actual %h", $time, want.ch, out_char);
                        bad_count++;
                    end
                    if (char_valid !== want.valid)
                    begin
                        $display("%0t: char_valid expected %b actual %b",
                                 $time, want.valid, char_valid);
                        bad_count++;
                    end
                    if (token_end !== want.last)
                    begin
                        $display("%0t: token_end expected %b actual %b",
                                 $time, want.last, token_end);
                        bad_count++;
                    end
                end
            end
            if (hold_left > 0)
                pop <= 1'b0;
            else
                pop <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("word_token_normalizer: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_text("U.S.");
        add_text("A.");
        add_text("'Tom's");
        add_text("is'");
        add_text("X'S");
        add_text("!?");
        add_byte(8'h00, 1'b0, 1'b1);
        add_byte(8'hFF, 1'b1, 1'b1);
        add_byte("a", 1'b1, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b1);
        add_byte("Z", 1'b1, 1'b1);
        add_random_phase();

        while (pending_bytes.size() != 0)
            @(negedge clk);
        send_idle = 85;
        recv_idle = 31;
        phase = 1;
        add_random_phase();

        while (pending_bytes.size() != 0)
            @(negedge clk);
        send_idle = 0;
        recv_idle = 0;
        phase = 2;
        add_random_phase();

        while (pending_bytes.size() != 0 || push || want_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        if (bad_count == 0 && want_results.size() == 0)
            $display("word_token_normalizer: match");
        else
            $display("word_token_normalizer: mismatch");
        $finish;
    end

endmodule
